/* design/sls_pkg.sv */
// package: shared types and constants for the list scheduler
package sls_pkg;

  localparam int IdW   = 8;
  localparam int TimeW = 16;
  localparam int ResW  = 23;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic [IdW-1:0] ident;
    logic [ResW-1:0] fin;
    logic [ResW-1:0] mspan;
    logic last;
  } result_t;

endpackage

/* design/schrage_list_scheduler.sv */
// top level: task loader, schedule sequencer and result register
//
// tasks arrive on the s_axis channel, one item per cycle while loading;
// s_axis_tdata = {tail_time, proc_time, release_time, task_id} and s_axis_tlast
// marks the final task of a set (the MAX_TASKS-th task also closes the set).
// after the last task the block runs the schedule and accepts no new task until
// every result of the set has been taken on m_axis.
// m_axis_tdata = {zero pad, makespan, finish_time, sched_id}, m_axis_tlast marks
// the final result.
// each scheduled task takes one scan over the stored set, one decision step and
// one emit step, plus another scan and decision step whenever the clock must
// jump to the next release; the scan reads one stored task per cycle from the
// task memory. results wait in an output register; a stalled receiver holds the
// next result in the emit step. reset empties the set and clears the output
// valid; the task memory itself is not cleared.
module schrage_list_scheduler
  import sls_pkg::*;
#(
  parameter int MAX_TASKS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // task_id, release_time, proc_time, tail_time from bit 0 up
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sched_id, finish_time, makespan, zero pad from bit 0 up
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int MemW = IdW + 3 * TimeW;

  logic [MemW-1:0] mem [MAX_TASKS];
  logic [MemW-1:0] rd_data;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;

  logic [MAX_TASKS-1:0] done;
  logic [MAX_TASKS-1:0] done_next;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] scan, scan_next;
  logic [CW-1:0] emitted, emitted_next;
  logic [ResW-1:0] clock_time, clock_time_next;
  logic [ResW-1:0] max_del, max_del_next;

  // best ready candidate and earliest pending release of the current scan
  logic            best_ok, best_ok_next;
  logic [AW-1:0]   best_idx, best_idx_next;
  logic [IdW-1:0]  best_id, best_id_next;
  logic [TimeW-1:0] best_proc, best_proc_next;
  logic [TimeW-1:0] best_tail, best_tail_next;
  logic [TimeW-1:0] min_rel, min_rel_next;

  logic    rd_valid, rd_valid_next;
  logic [AW-1:0] rd_idx;

  result_t res, res_next;
  logic    out_valid, out_valid_next;

  logic [IdW-1:0]   r_id;
  logic [TimeW-1:0] r_rel, r_proc, r_tail;
  logic [ResW-1:0]  fin, del;
  logic             load_acc, close_set;

  assign {r_tail, r_proc, r_rel, r_id} = rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= s_axis_tdata[MemW-1:0];
    end
    rd_data <= mem[rd_addr];
  end

  assign s_axis_tready = (state == ST_LOAD);
  assign load_acc = s_axis_tvalid && s_axis_tready;
  assign mem_we = load_acc;
  assign close_set = s_axis_tlast || (count == CW'(MAX_TASKS - 1));
  assign rd_addr = scan[AW-1:0];

  assign fin = clock_time + ResW'(best_proc);
  assign del = fin + ResW'(best_tail);

  always_comb begin
    state_next = state;
    count_next = count;
    scan_next = scan;
    emitted_next = emitted;
    clock_time_next = clock_time;
    max_del_next = max_del;
    best_ok_next = best_ok;
    best_idx_next = best_idx;
    best_id_next = best_id;
    best_proc_next = best_proc;
    best_tail_next = best_tail;
    min_rel_next = min_rel;
    done_next = done;
    rd_valid_next = 1'b0;
    res_next = res;
    out_valid_next = out_valid && !m_axis_tready;

    case (state)
      ST_LOAD: begin
        if (load_acc) begin
          count_next = count + 1'b1;
          if (close_set) begin
            state_next = ST_SCAN;
            scan_next = '0;
            emitted_next = '0;
            clock_time_next = '0;
            max_del_next = '0;
            done_next = '0;
            best_ok_next = 1'b0;
            min_rel_next = '1;
          end
        end
      end
      ST_SCAN: begin
        if (scan != count) begin
          rd_valid_next = 1'b1;
          scan_next = scan + 1'b1;
        end else if (!rd_valid) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        if (best_ok) begin
          state_next = ST_EMIT;
        end else begin
          clock_time_next = ResW'(min_rel);
          state_next = ST_SCAN;
          scan_next = '0;
          min_rel_next = '1;
        end
      end
      ST_EMIT: begin
        if (!out_valid || m_axis_tready) begin
          res_next.ident = best_id;
          res_next.fin = fin;
          res_next.mspan = (del > max_del) ? del : max_del;
          res_next.last = (CW'(emitted + 1'b1) == count);
          out_valid_next = 1'b1;
          max_del_next = res_next.mspan;
          clock_time_next = fin;
          done_next[best_idx] = 1'b1;
          emitted_next = emitted + 1'b1;
          best_ok_next = 1'b0;
          min_rel_next = '1;
          scan_next = '0;
          state_next = res_next.last ? ST_WAIT : ST_SCAN;
        end
      end
      ST_WAIT: begin
        if (!out_valid_next) begin
          state_next = ST_LOAD;
          count_next = '0;
        end
      end
      default: state_next = ST_LOAD;
    endcase

    // scan datapath: entry read last cycle is evaluated now
    if (rd_valid && !done[rd_idx]) begin
      if (ResW'(r_rel) <= clock_time) begin
        if (!best_ok || r_tail > best_tail) begin
          best_ok_next = 1'b1;
          best_idx_next = rd_idx;
          best_id_next = r_id;
          best_proc_next = r_proc;
          best_tail_next = r_tail;
        end
      end else if (r_rel < min_rel) begin
        min_rel_next = r_rel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      rd_valid <= 1'b0;
      out_valid <= 1'b0;
      done <= '0;
      best_ok <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rd_valid <= rd_valid_next;
      out_valid <= out_valid_next;
      done <= done_next;
      best_ok <= best_ok_next;
    end
    rd_idx <= scan[AW-1:0];
    scan <= scan_next;
    emitted <= emitted_next;
    clock_time <= clock_time_next;
    max_del <= max_del_next;
    best_idx <= best_idx_next;
    best_id <= best_id_next;
    best_proc <= best_proc_next;
    best_tail <= best_tail_next;
    min_rel <= min_rel_next;
    res <= res_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {{(56 - IdW - 2 * ResW){1'b0}}, res.mspan, res.fin, res.ident};
  assign m_axis_tlast = res.last;

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD) |-> !s_axis_tready)
    else $error("task taken while scheduling");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TASKS))
    else $error("task count overflow");
  a_emit_best: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> best_ok)
    else $error("emit without ready task");
  a_mspan_mono: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && $past(state) == ST_EMIT) |-> $stable(max_del))
    else $error("makespan changed while stalled");

endmodule
